/* rtl/core/mes_pkg.sv */
// ----------------------------------------------------------------------------
// mes_pkg: shared constants for the multichannel EMA smoother
// Field widths, stream packing and divider sizing.
// ----------------------------------------------------------------------------
package mes_pkg;

  localparam int unsigned JOINTS       = 25;
  localparam int unsigned AXES         = 3;
  localparam int unsigned CHANNELS_DEF = JOINTS * AXES;

  localparam int unsigned CH_W     = 7;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned DIV_W    = 16;

  // stream word: channel in the low bits, then the sample, padded to bytes
  localparam int unsigned PAYLOAD_W = CH_W + SAMPLE_W;
  localparam int unsigned TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
  localparam int unsigned PAD_W     = TDATA_W - PAYLOAD_W;

  localparam logic [DIV_W-1:0] DIV_RESET = 16'd4;

  // difference magnitude needs one bit more than the sample
  localparam int unsigned QUOT_W = SAMPLE_W + 1;
  localparam int unsigned CNT_W  = $clog2(QUOT_W + 1);

endpackage

/* rtl/core/multichannel_ema_smoother.sv */
// ----------------------------------------------------------------------------
// multichannel_ema_smoother
// Per-channel exponential moving average over skeleton joint coordinates.
// ----------------------------------------------------------------------------
// One input word gives one output word. A word on a first frame seeds the
// channel's stored value and comes out unchanged; later words move the stored
// value toward the sample by (sample - stored) / smoothing_divisor, truncated
// toward zero, and the new value comes out. A divisor of zero acts as one.
// Channels at or above CHANNELS pass the sample through and touch no state.
// The block takes one word at a time. A smoothed word passes a memory read,
// the bit-serial divider and a write-back into the result register and the
// store; a seed or pass-through word skips the divider. The next word is
// accepted in the cycle after the write-back, and the write-back waits while
// the output register still holds a result that has not been taken.
// That next word is accepted even while the previous result still waits in
// the output register. A channel must be seeded before it is smoothed; its
// stored value is undefined until then.
// ----------------------------------------------------------------------------
module multichannel_ema_smoother #(
  parameter int unsigned CHANNELS = mes_pkg::CHANNELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: smoothing_divisor
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mes_pkg::DIV_W-1:0]    cfg_data_i,
  // input words
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [mes_pkg::TDATA_W-1:0]  s_axis_tdata_i,  // channel[6:0], sample[38:7]
  input  logic                         s_axis_tuser_i,  // first_frame
  // output words
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [mes_pkg::TDATA_W-1:0]  m_axis_tdata_o   // out_channel[6:0], smoothed[38:7]
);

  localparam int unsigned AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CW  = mes_pkg::CH_W;
  localparam int unsigned SW  = mes_pkg::SAMPLE_W;
  localparam int unsigned QW  = mes_pkg::QUOT_W;
  localparam int unsigned DW  = mes_pkg::DIV_W;
  localparam int unsigned EXW = CW + AW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [DW-1:0]           div_q;
  logic [CW-1:0]           ch_q;
  logic [SW-1:0]           sample_q;
  logic [AW-1:0]           addr_q;
  logic                    in_range_q;
  logic                    first_q;
  logic                    bypass_q;
  logic                    neg_q;
  logic [DW:0]             rem_q;
  logic [QW-1:0]           quo_q;
  logic [mes_pkg::CNT_W-1:0] cnt_q;
  logic                    out_valid_q;
  logic [CW-1:0]           out_ch_q;
  logic [SW-1:0]           out_val_q;

  logic [SW-1:0]           mem [CHANNELS];
  logic [SW-1:0]           rdata_q;

  logic                    in_acc;
  logic                    out_free;
  logic                    load_out;
  logic                    mem_we;
  logic [CW-1:0]           in_ch;
  logic [EXW-1:0]          ch_ext;
  logic                    in_range;
  logic [QW-1:0]           diff;
  logic [QW-1:0]           mag;
  logic [DW:0]             dvs;
  logic [DW:0]             shifted;
  logic                    ge;
  logic [QW:0]             step;
  logic [QW:0]             sum;
  logic [SW-1:0]           result;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign load_out        = (state_q == ST_DONE) && out_free;
  assign mem_we          = load_out && in_range_q;

  assign in_ch    = s_axis_tdata_i[CW-1:0];
  assign ch_ext   = {{AW{1'b0}}, in_ch};
  assign in_range = (ch_ext < EXW'(CHANNELS));

  // difference at one bit wider than the sample, then its magnitude
  assign diff = {sample_q[SW-1], sample_q} - {rdata_q[SW-1], rdata_q};
  assign mag  = diff[QW-1] ? (~diff + QW'(1)) : diff;

  assign dvs     = (div_q == '0) ? (DW+1)'(1) : {1'b0, div_q};
  assign shifted = {rem_q[DW-1:0], quo_q[QW-1]};
  assign ge      = (shifted >= dvs);

  assign step   = neg_q ? (~{1'b0, quo_q} + (QW+1)'(1)) : {1'b0, quo_q};
  assign sum    = {{2{rdata_q[SW-1]}}, rdata_q} + step;
  assign result = bypass_q ? sample_q : sum[SW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_READ;
      ST_READ: state_d = (first_q || !in_range_q) ? ST_DONE : ST_DIV;
      ST_DIV:  if (cnt_q == mes_pkg::CNT_W'(QW - 1)) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_q       <= mes_pkg::DIV_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        div_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload and the bit-serial divider
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q       <= in_ch;
      sample_q   <= s_axis_tdata_i[CW+SW-1:CW];
      addr_q     <= ch_ext[AW-1:0];
      in_range_q <= in_range;
      first_q    <= s_axis_tuser_i;
    end
    if (state_q == ST_READ) begin
      bypass_q <= first_q || !in_range_q;
      neg_q    <= diff[QW-1];
      quo_q    <= mag;
      rem_q    <= '0;
      cnt_q    <= '0;
    end else if (state_q == ST_DIV) begin
      rem_q <= ge ? (shifted - dvs) : shifted;
      quo_q <= {quo_q[QW-2:0], ge};
      cnt_q <= cnt_q + mes_pkg::CNT_W'(1);
    end
    if (load_out) begin
      out_ch_q  <= ch_q;
      out_val_q <= result;
    end
  end

  // channel store: one read port, one write port, registered read data
  always_ff @(posedge clk_i) begin
    if (in_acc && in_range) begin
      rdata_q <= mem[ch_ext[AW-1:0]];
    end
    if (mem_we) begin
      mem[addr_q] <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{mes_pkg::PAD_W{1'b0}}, out_val_q, out_ch_q};

  // a new result only ever comes from the write-back state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid_o)
    else $error("result register not loaded after write-back");

  // a seed or out-of-range word comes out as the sample itself
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && bypass_q) |=> (m_axis_tdata_o[CW+SW-1:CW] == $past(sample_q)))
    else $error("pass-through word altered");

  // the store is never written for a channel beyond the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (addr_q < AW'(CHANNELS - 1) || addr_q == AW'(CHANNELS - 1)))
    else $error("write beyond channel store");

  // the divider always finishes within its fixed step count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q < mes_pkg::CNT_W'(QW)))
    else $error("divider overran its step count");

endmodule
